>>> rtl/svsd_pkg.sv
// shared constants and rounding helpers for the scaled vector sum block
package svsd_pkg;

    localparam logic [63:0] QNAN    = 64'h7FF8_0000_0000_0000;
    localparam logic [10:0] EXP_MAX = 11'h7FF;

    typedef logic [63:0] t_fp64;

    // leading zero count of a left-aligned vector, 128 when all zero
    function automatic logic [7:0] lzc128(input logic [127:0] v);
        logic [7:0] n;
        n = 8'd128;
        for (int i = 0; i < 128; i++) begin
            if (v[i]) begin
                n = 8'(127 - i);
            end
        end
        return n;
    endfunction

    // round to nearest even and pack; ef 0 means subnormal
    function automatic t_fp64 round_pack(input logic s, input logic [11:0] ef,
                                         input logic [52:0] mant, input logic g,
                                         input logic st);
        logic        up;
        logic [53:0] m2;
        logic [12:0] e;
        logic [51:0] f;
        up = g & (st | mant[0]);
        m2 = {1'b0, mant} + {53'b0, up};
        if (m2[53]) begin
            e = {1'b0, ef} + 13'd1;
            f = '0;
        end else if (ef == '0 && m2[52]) begin
            e = 13'd1;
            f = m2[51:0];
        end else begin
            e = {1'b0, ef};
            f = m2[51:0];
        end
        if (e >= {2'b0, EXP_MAX}) begin
            return {s, EXP_MAX, 52'b0};
        end
        return {s, e[10:0], f};
    endfunction

endpackage

>>> rtl/svsd_fmul.sv
// seven stage binary64 multiplier with round to nearest even
module svsd_fmul (
    input  logic               i_clk,
    input  logic               i_en,
    input  svsd_pkg::t_fp64    i_a,
    input  svsd_pkg::t_fp64    i_b,
    output svsd_pkg::t_fp64    o_p
);
    // stage 1: unpack and partial products
    logic [10:0] ea, eb, ea1, eb1;
    logic [52:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [53:0] r1_ll;
    logic [52:0] r1_lh, r1_hl;
    logic [51:0] r1_hh;
    logic [11:0] r1_esum;
    logic        r1_s, r1_nan, r1_inf, r1_zero;

    assign ea     = i_a[62:52];
    assign eb     = i_b[62:52];
    assign ea1    = (ea == '0) ? 11'd1 : ea;
    assign eb1    = (eb == '0) ? 11'd1 : eb;
    assign ma     = {ea != '0, i_a[51:0]};
    assign mb     = {eb != '0, i_b[51:0]};
    assign nan_a  = (ea == svsd_pkg::EXP_MAX) && (i_a[51:0] != '0);
    assign nan_b  = (eb == svsd_pkg::EXP_MAX) && (i_b[51:0] != '0);
    assign inf_a  = (ea == svsd_pkg::EXP_MAX) && (i_a[51:0] == '0);
    assign inf_b  = (eb == svsd_pkg::EXP_MAX) && (i_b[51:0] == '0);
    assign zero_a = (i_a[62:0] == '0);
    assign zero_b = (i_b[62:0] == '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ll   <= 54'(ma[26:0]) * 54'(mb[26:0]);
            r1_lh   <= 53'(ma[26:0]) * 53'(mb[52:27]);
            r1_hl   <= 53'(ma[52:27]) * 53'(mb[26:0]);
            r1_hh   <= 52'(ma[52:27]) * 52'(mb[52:27]);
            r1_esum <= {1'b0, ea1} + {1'b0, eb1};
            r1_s    <= i_a[63] ^ i_b[63];
            r1_nan  <= nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a);
            r1_inf  <= inf_a | inf_b;
            r1_zero <= zero_a | zero_b;
        end
    end

    // stage 2: middle terms and the non-overlapping outer terms
    logic [105:0] r2_cat;
    logic [53:0]  r2_mid;
    logic [11:0]  r2_esum;
    logic         r2_s, r2_nan, r2_inf, r2_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_cat  <= {r1_hh, r1_ll};
            r2_mid  <= {1'b0, r1_lh} + {1'b0, r1_hl};
            r2_esum <= r1_esum;
            r2_s    <= r1_s;
            r2_nan  <= r1_nan;
            r2_inf  <= r1_inf;
            r2_zero <= r1_zero;
        end
    end

    // stage 3: full product
    logic [105:0] r3_p;
    logic [11:0]  r3_esum;
    logic         r3_s, r3_nan, r3_inf, r3_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p    <= r2_cat + {25'b0, r2_mid, 27'b0};
            r3_esum <= r2_esum;
            r3_s    <= r2_s;
            r3_nan  <= r2_nan;
            r3_inf  <= r2_inf;
            r3_zero <= r2_zero;
        end
    end

    // stage 4: leading zero count
    logic [7:0]   lz_full;
    logic [105:0] r4_p;
    logic [6:0]   r4_lz;
    logic [11:0]  r4_esum;
    logic         r4_s, r4_nan, r4_inf, r4_zero;

    assign lz_full = svsd_pkg::lzc128({r3_p, 22'b0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_p    <= r3_p;
            r4_lz   <= lz_full[6:0];
            r4_esum <= r3_esum;
            r4_s    <= r3_s;
            r4_nan  <= r3_nan;
            r4_inf  <= r3_inf;
            r4_zero <= r3_zero;
        end
    end

    // stage 5: normalize left, fold low bits into sticky
    logic [105:0] pn;
    logic [54:0]  r5_w;
    logic [13:0]  r5_er;
    logic         r5_s, r5_nan, r5_inf, r5_zero;

    assign pn = r4_p << r4_lz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_w    <= {pn[105:52], |pn[51:0]};
            r5_er   <= {2'b0, r4_esum} - {7'b0, r4_lz} - 14'd1022;
            r5_s    <= r4_s;
            r5_nan  <= r4_nan;
            r5_inf  <= r4_inf;
            r5_zero <= r4_zero;
        end
    end

    // stage 6: denormalize tiny results
    logic        tiny;
    logic [13:0] sh_full;
    logic [5:0]  sh;
    logic [54:0] wd, lost;
    logic [52:0] r6_mant;
    logic [11:0] r6_ef;
    logic        r6_g, r6_st, r6_s, r6_nan, r6_inf, r6_zero;

    assign tiny    = r5_er[13] || (r5_er == '0);
    assign sh_full = 14'd1 - r5_er;
    assign sh      = (sh_full > 14'd63) ? 6'd63 : sh_full[5:0];
    assign wd      = tiny ? (r5_w >> sh) : r5_w;
    assign lost    = tiny ? (r5_w & ~({55{1'b1}} << sh)) : '0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_mant <= wd[54:2];
            r6_g    <= wd[1];
            r6_st   <= wd[0] | (|lost);
            r6_ef   <= tiny ? 12'd0 : r5_er[11:0];
            r6_s    <= r5_s;
            r6_nan  <= r5_nan;
            r6_inf  <= r5_inf;
            r6_zero <= r5_zero;
        end
    end

    // stage 7: round and pack
    svsd_pkg::t_fp64 r7_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r6_nan) begin
                r7_p <= svsd_pkg::QNAN;
            end else if (r6_inf) begin
                r7_p <= {r6_s, svsd_pkg::EXP_MAX, 52'b0};
            end else if (r6_zero) begin
                r7_p <= {r6_s, 63'b0};
            end else begin
                r7_p <= svsd_pkg::round_pack(r6_s, r6_ef, r6_mant, r6_g, r6_st);
            end
        end
    end

    assign o_p = r7_p;
endmodule

>>> rtl/svsd_fadd.sv
// six stage binary64 adder with a product bypass at the last stage
module svsd_fadd (
    input  logic               i_clk,
    input  logic               i_en,
    input  svsd_pkg::t_fp64    i_a,
    input  svsd_pkg::t_fp64    i_b,
    input  logic               i_byp,
    input  svsd_pkg::t_fp64    i_byp_val,
    output svsd_pkg::t_fp64    o_res
);
    // stage 1: unpack, order by magnitude
    logic            swap;
    svsd_pkg::t_fp64 big, sml;
    logic [10:0]     ebg, esm, ebg1, esm1;
    logic            nan_a, nan_b, inf_a, inf_b;
    logic [52:0]     r1_bm, r1_sm;
    logic [10:0]     r1_e, r1_d;
    logic            r1_s, r1_sub, r1_zs, r1_nan, r1_inf, r1_is;
    logic            r1_byp;
    svsd_pkg::t_fp64 r1_bv;

    assign swap  = i_b[62:0] > i_a[62:0];
    assign big   = swap ? i_b : i_a;
    assign sml   = swap ? i_a : i_b;
    assign ebg   = big[62:52];
    assign esm   = sml[62:52];
    assign ebg1  = (ebg == '0) ? 11'd1 : ebg;
    assign esm1  = (esm == '0) ? 11'd1 : esm;
    assign nan_a = (i_a[62:52] == svsd_pkg::EXP_MAX) && (i_a[51:0] != '0);
    assign nan_b = (i_b[62:52] == svsd_pkg::EXP_MAX) && (i_b[51:0] != '0);
    assign inf_a = (i_a[62:52] == svsd_pkg::EXP_MAX) && (i_a[51:0] == '0);
    assign inf_b = (i_b[62:52] == svsd_pkg::EXP_MAX) && (i_b[51:0] == '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_bm  <= {ebg != '0, big[51:0]};
            r1_sm  <= {esm != '0, sml[51:0]};
            r1_e   <= ebg1;
            r1_d   <= ebg1 - esm1;
            r1_s   <= big[63];
            r1_sub <= i_a[63] ^ i_b[63];
            r1_zs  <= (i_a[63] ^ i_b[63]) ? 1'b0 : i_a[63];
            r1_nan <= nan_a | nan_b | (inf_a & inf_b & (i_a[63] ^ i_b[63]));
            r1_inf <= inf_a | inf_b;
            r1_is  <= inf_a ? i_a[63] : i_b[63];
            r1_byp <= i_byp;
            r1_bv  <= i_byp_val;
        end
    end

    // stage 2: align the smaller operand with guard, round and sticky bits
    logic [5:0]  d6;
    logic [55:0] sx, ss, lost;
    logic [55:0] r2_bw, r2_sw;
    logic [10:0] r2_e;
    logic        r2_s, r2_sub, r2_zs, r2_nan, r2_inf, r2_is, r2_byp;
    svsd_pkg::t_fp64 r2_bv;

    assign d6   = (r1_d > 11'd63) ? 6'd63 : r1_d[5:0];
    assign sx   = {r1_sm, 3'b0};
    assign ss   = sx >> d6;
    assign lost = sx & ~({56{1'b1}} << d6);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_bw  <= {r1_bm, 3'b0};
            r2_sw  <= {ss[55:1], ss[0] | (|lost)};
            r2_e   <= r1_e;
            r2_s   <= r1_s;
            r2_sub <= r1_sub;
            r2_zs  <= r1_zs;
            r2_nan <= r1_nan;
            r2_inf <= r1_inf;
            r2_is  <= r1_is;
            r2_byp <= r1_byp;
            r2_bv  <= r1_bv;
        end
    end

    // stage 3: add or subtract magnitudes
    logic [56:0] r3_sum;
    logic [10:0] r3_e;
    logic        r3_s, r3_zs, r3_nan, r3_inf, r3_is, r3_byp;
    svsd_pkg::t_fp64 r3_bv;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sum <= r2_sub ? ({1'b0, r2_bw} - {1'b0, r2_sw})
                             : ({1'b0, r2_bw} + {1'b0, r2_sw});
            r3_e   <= r2_e;
            r3_s   <= r2_s;
            r3_zs  <= r2_zs;
            r3_nan <= r2_nan;
            r3_inf <= r2_inf;
            r3_is  <= r2_is;
            r3_byp <= r2_byp;
            r3_bv  <= r2_bv;
        end
    end

    // stage 4: leading zero count
    logic [7:0]  lz_full;
    logic [56:0] r4_sum;
    logic [6:0]  r4_lz;
    logic [10:0] r4_e;
    logic        r4_s, r4_zs, r4_zero, r4_nan, r4_inf, r4_is, r4_byp;
    svsd_pkg::t_fp64 r4_bv;

    assign lz_full = svsd_pkg::lzc128({r3_sum, 71'b0});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sum  <= r3_sum;
            r4_lz   <= lz_full[6:0];
            r4_zero <= (r3_sum == '0);
            r4_e    <= r3_e;
            r4_s    <= r3_s;
            r4_zs   <= r3_zs;
            r4_nan  <= r3_nan;
            r4_inf  <= r3_inf;
            r4_is   <= r3_is;
            r4_byp  <= r3_byp;
            r4_bv   <= r3_bv;
        end
    end

    // stage 5: normalize, never below the smallest exponent
    logic [6:0]  lzm1, sh;
    logic [10:0] em1;
    logic [56:0] shl;
    logic [55:0] w;
    logic [11:0] er;
    logic [55:0] r5_w;
    logic [11:0] r5_ef;
    logic        r5_s, r5_zs, r5_zero, r5_nan, r5_inf, r5_is, r5_byp;
    svsd_pkg::t_fp64 r5_bv;

    assign lzm1 = r4_lz - 7'd1;
    assign em1  = r4_e - 11'd1;
    assign sh   = ({4'b0, lzm1} < em1) ? lzm1 : em1[6:0];
    assign shl  = r4_sum << sh;

    always_comb begin
        if (r4_sum[56]) begin
            w  = {r4_sum[56:2], r4_sum[1] | r4_sum[0]};
            er = {1'b0, r4_e} + 12'd1;
        end else begin
            w  = shl[55:0];
            er = {1'b0, r4_e - {4'b0, sh}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_w    <= w;
            r5_ef   <= w[55] ? er : 12'd0;
            r5_s    <= r4_s;
            r5_zs   <= r4_zs;
            r5_zero <= r4_zero;
            r5_nan  <= r4_nan;
            r5_inf  <= r4_inf;
            r5_is   <= r4_is;
            r5_byp  <= r4_byp;
            r5_bv   <= r4_bv;
        end
    end

    // stage 6: round, pack, special values and bypass
    svsd_pkg::t_fp64 r6_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r5_byp) begin
                r6_res <= r5_bv;
            end else if (r5_nan) begin
                r6_res <= svsd_pkg::QNAN;
            end else if (r5_inf) begin
                r6_res <= {r5_is, svsd_pkg::EXP_MAX, 52'b0};
            end else if (r5_zero) begin
                r6_res <= {r5_zs, 63'b0};
            end else begin
                r6_res <= svsd_pkg::round_pack(r5_s, r5_ef, r5_w[55:3], r5_w[2],
                                               |r5_w[1:0]);
            end
        end
    end

    assign o_res = r6_res;
endmodule

>>> rtl/scaled_vector_sum_double.sv
// top level: streaming a*x + b*y on binary64 elements
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_x_bits, i_y_bits, i_last_in
//  out     | output    | o_out_valid / i_out_ready  | o_result_bits, o_last_out
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// one item per cycle sustained while the output is not stalled; each item passes through
// 7 multiplier stages, then 6 adder stages, and the last adder stage is the output register
// the whole pipeline advances together whenever the output register is empty or taken,
// so a stall freezes every stage and bubbles in flight stay where they are
// synchronous active-low reset clears the valid line and both scale factors (+0.0)
module scaled_vector_sum_double (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_x_bits,
    input  logic [63:0] i_y_bits,
    input  logic        i_last_in,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_result_bits,
    output logic        o_last_out
);
    localparam int MUL_LAT = 7;
    localparam int LAT     = 13;

    localparam logic IDX_A = 1'b0;
    localparam logic IDX_B = 1'b1;

    // scale factor registers
    svsd_pkg::t_fp64 r_coef_a, r_coef_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= '0;
            r_coef_b <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                IDX_A:   r_coef_a <= i_cfg_data;
                IDX_B:   r_coef_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: free slot at the output or the result is being taken
    logic en;
    logic [LAT-1:0] r_vld, r_last;

    assign en         = ~r_vld[LAT-1] | i_out_ready;
    assign o_in_ready = en;

    // valid and last travel beside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last <= {r_last[LAT-2:0], i_last_in};
        end
    end

    // shortcut selection: a == 0 gives b*y alone, else b == 0 gives a*x alone
    logic a_zero, b_zero;
    logic [MUL_LAT-1:0] r_byp, r_sel_y;

    assign a_zero = (r_coef_a[62:0] == '0);
    assign b_zero = (r_coef_b[62:0] == '0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_byp   <= {r_byp[MUL_LAT-2:0], a_zero | b_zero};
            r_sel_y <= {r_sel_y[MUL_LAT-2:0], a_zero};
        end
    end

    // two product pipelines in lockstep
    svsd_pkg::t_fp64 px, py;

    svsd_fmul u_mul_ax (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_coef_a),
        .i_b   (i_x_bits),
        .o_p   (px)
    );

    svsd_fmul u_mul_by (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_coef_b),
        .i_b   (i_y_bits),
        .o_p   (py)
    );

    // sum of the rounded products, or one product passed through
    svsd_pkg::t_fp64 res;

    svsd_fadd u_add (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_a       (py),
        .i_b       (px),
        .i_byp     (r_byp[MUL_LAT-1]),
        .i_byp_val (r_sel_y[MUL_LAT-1] ? py : px),
        .o_res     (res)
    );

    assign o_out_valid   = r_vld[LAT-1];
    assign o_result_bits = res;
    assign o_last_out    = r_last[LAT-1];
endmodule

>>> rtl/svsd_checker.sv
// port-level checks for the scaled vector sum block and their binding
module svsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_result_bits
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_result_bits))
        else $error("result changed while stalled");

    // a full, stalled output blocks new items
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("item taken while output stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // every nan comes out canonical
    a_nan_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_bits[62:52] == svsd_pkg::EXP_MAX
            && o_result_bits[51:0] != '0 |-> o_result_bits == svsd_pkg::QNAN)
        else $error("non-canonical nan");
endmodule

bind scaled_vector_sum_double svsd_checker u_svsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_bits (o_result_bits)
);
